FILE: src/fcds_pkg.sv
// Shared types and constants for the fractional clock divider search.
// Holds the input/output beat structs, the sequencer states and the
// divider and search widths. No dependencies.
package fcds_pkg;

  // Default largest denominator tried by the search
  localparam int Y_MAX_DEF = 255;

  // Divider geometry: dividend is (rate * 256) << 16, 43 bits
  localparam int RATE_W     = 19;
  localparam int PCLK_W     = 29;
  localparam int DIVIDEND_W = RATE_W + 24;
  localparam int RATIO_W    = 32;
  localparam int DIV_CNT_W  = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

  // Fractional error constants, in 1/65536 units
  localparam logic [15:0] FRAC_HALF  = 16'h8000;
  localparam logic [16:0] FRAC_ONE   = 17'h10000;
  localparam logic [15:0] ERR_START  = 16'hFFFF;

  // Input beat
  typedef struct packed {
    logic [RATE_W-1:0] sample_rate_hz;
    logic [PCLK_W-1:0] peripheral_clock_hz;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [7:0]  y_div;
    logic [7:0]  x_div;
    logic [15:0] rate_word;
    logic [15:0] best_error;
  } out_beat_t;

  // Top-level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEARCH,
    ST_OUT
  } seq_state_t;

endpackage

FILE: src/fcds_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Produces the 32-bit ratio (rate*256 << 16) / peripheral clock.
// Depends on fcds_pkg.
module fcds_divider
  import fcds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [PCLK_W-1:0]     divisor,
  output logic                  done,
  output logic [RATIO_W-1:0]    quotient
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [PCLK_W-1:0]     rem_r, rem_nxt;
  logic [PCLK_W-1:0]     dvs_r, dvs_nxt;

  logic [PCLK_W:0] trial;
  logic [PCLK_W:0] diff;
  logic            fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  // A zero divisor always fits, so the quotient saturates to all ones.
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      rem_nxt = fits ? diff[PCLK_W-1:0] : trial[PCLK_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      // Finish after the last quotient bit
      if (cnt_r == DIV_LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  // Keep only the low 32 bits of the quotient
  assign done     = done_r;
  assign quotient = quo_r[RATIO_W-1:0];

endmodule

FILE: src/fcds_search.sv
// Denominator search: walks Y from Y_MAX down to 1, one Y per cycle, stopping early on an exact fit.
// Y*ratio is kept as a running product and stepped down by one subtract.
// Depends on fcds_pkg.
module fcds_search
  import fcds_pkg::*;
#(
  parameter int Y_MAX = Y_MAX_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RATIO_W-1:0] ratio,
  output logic               done,
  output out_beat_t          result
);

  localparam logic [7:0] Y_TOP = 8'(Y_MAX);

  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [7:0]         y_r, y_nxt;
  logic [RATIO_W-1:0] prod_r, prod_nxt;
  logic [RATIO_W-1:0] ratio_r, ratio_nxt;
  logic [15:0]        best_r, best_nxt;
  logic [7:0]         by_r, by_nxt;
  logic [7:0]         bx_r, bx_nxt;

  logic [39:0]        start_prod;
  logic [15:0]        frac;
  logic [15:0]        err;
  logic               better;
  logic               hit;

  // Starting product Y_MAX * ratio, wrapped to 32 bits
  assign start_prod = 40'(ratio) * 40'(Y_TOP);

  // Distance of the fraction from the nearest integer
  assign frac   = prod_r[15:0];
  assign err    = (frac > FRAC_HALF) ? 16'(FRAC_ONE - 17'(frac)) : frac;
  assign hit    = (err == '0);
  assign better = (err < best_r);

  always_comb begin
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    y_nxt     = y_r;
    prod_nxt  = prod_r;
    ratio_nxt = ratio_r;
    best_nxt  = best_r;
    by_nxt    = by_r;
    bx_nxt    = bx_r;
    if (start) begin
      run_nxt   = 1'b1;
      y_nxt     = Y_TOP;
      prod_nxt  = start_prod[RATIO_W-1:0];
      ratio_nxt = ratio;
      best_nxt  = ERR_START;
      by_nxt    = '0;
      bx_nxt    = '0;
    end else if (run_r) begin
      // Keep a strictly better candidate; round X up when the fraction is half or more
      if (better) begin
        best_nxt = err;
        by_nxt   = y_r;
        bx_nxt   = prod_r[23:16] + {7'b0, frac[15]};
      end
      // Advance to the next denominator
      y_nxt    = y_r - 1'b1;
      prod_nxt = prod_r - ratio_r;
      // Stop on an exact fit or after Y = 1
      if (hit || (y_r == 8'd1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    y_r     <= y_nxt;
    prod_r  <= prod_nxt;
    ratio_r <= ratio_nxt;
    best_r  <= best_nxt;
    by_r    <= by_nxt;
    bx_r    <= bx_nxt;
  end

  // Pack the best candidate
  assign done              = done_r;
  assign result.y_div      = by_r;
  assign result.x_div      = bx_r;
  assign result.rate_word  = {bx_r, by_r};
  assign result.best_error = best_r;

endmodule

FILE: src/fractional_clock_divider_search.sv
// Top level of the fractional clock divider search.
// Sequences the serial divider and the denominator search; holds the result beat.
// Depends on fcds_pkg, fcds_divider and fcds_search.

// One beat in gives one result beat: the X/Y fractional divider settings whose
// ratio best matches 256 times the sample rate over the peripheral clock. The
// block works on one beat at a time and drops in_ready until the result has been
// taken. Once a beat is taken, the bit-serial divider forms the 16.16 ratio and
// its registered done strobe starts the search, which tries denominators from
// Y_MAX down to the first exact fit or to 1. The search done strobe loads the
// result register and out_valid rises. in_ready returns in the cycle after the
// result beat is taken.
module fractional_clock_divider_search
  import fcds_pkg::*;
#(
  parameter int Y_MAX = Y_MAX_DEF
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  seq_state_t state_r, state_nxt;
  out_beat_t  out_r, out_nxt;

  logic                  div_start;
  logic                  div_done;
  logic [RATIO_W-1:0]    ratio;
  logic [DIVIDEND_W-1:0] dividend;
  logic                  srch_done;
  out_beat_t             srch_result;

  // Master clock is rate * 256, shifted up 16 for the 16.16 ratio
  assign dividend  = {in_data.sample_rate_hz, 24'h0};
  assign div_start = in_valid && in_ready;

  fcds_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (in_data.peripheral_clock_hz),
    .done     (div_done),
    .quotient (ratio)
  );

  fcds_search #(
    .Y_MAX (Y_MAX)
  ) u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_done),
    .ratio  (ratio),
    .done   (srch_done),
    .result (srch_result)
  );

  // Sequencer: next state and handshake outputs
  always_comb begin
    state_nxt = state_r;
    out_nxt   = out_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch_done) begin
          out_nxt   = srch_result;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule
